// ===== hw/rtl/kf_pkg.sv =====
package kf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_KERNEL = 15;

   localparam int MEM_AW    = $clog2(2 * (MAX_KERNEL / 2) * (MAX_WIDTH + 1) + 1);
   localparam int MEM_DEPTH = 1 << MEM_AW;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 11;

   localparam logic [CSR_IW-1:0] CSR_KERNEL_SIZE  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic       idle;
      logic       rd_win;
      logic       clr_acc;
      logic       rd_border;
      logic       take_border;
      logic       mult;
      logic       cmp;
      logic       div_init;
      logic       div_step;
      logic       load_out;
      logic [1:0] quad;
      logic [2:0] row;
      logic [2:0] col;
      logic [2:0] bitn;
   } kf_cmd_type;

   typedef struct packed {
      logic       accept;
      logic       emit;
      logic       interior;
      logic       rsp_free;
      logic [2:0] qm1;
   } kf_status_type;

endpackage

// ===== hw/rtl/kf_req_if.sv =====
interface kf_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] pixel_in;

   modport source (output valid, output operation, output pixel_in, input ready);
   modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface kf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== hw/rtl/kf_ctrl.sv =====
module kf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  kf_pkg::kf_status_type status,
   output kf_pkg::kf_cmd_type    cmd
);
   import kf_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_ACC   = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_DINIT = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_BRD   = 4'd7;
   localparam logic [3:0] ST_BRDW  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] quad_ff, quad_in;
   logic [2:0] row_ff, row_in;
   logic [2:0] col_ff, col_in;
   logic [2:0] bit_ff, bit_in;

   always_comb begin
      state_in = state_ff;
      quad_in  = quad_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      bit_in   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.accept && status.emit) begin
               quad_in = 2'd0;
               row_in  = 3'd0;
               col_in  = 3'd0;
               state_in = status.interior ? ST_READ : ST_BRD;
            end
         end
         ST_READ: begin
            if (col_ff == status.qm1) begin
               col_in = 3'd0;
               if (row_ff == status.qm1) begin
                  row_in   = 3'd0;
                  state_in = ST_ACC;
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end else begin
               col_in = col_ff + 3'd1;
            end
         end
         ST_ACC: state_in = ST_MUL;
         ST_MUL: state_in = ST_CMP;
         ST_CMP: begin
            if (quad_ff == 2'd3) begin
               state_in = ST_DINIT;
            end else begin
               quad_in  = quad_ff + 2'd1;
               state_in = ST_READ;
            end
         end
         ST_DINIT: begin
            bit_in   = 3'd7;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_BRD:  state_in = ST_BRDW;
         ST_BRDW: state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         quad_ff  <= 2'd0;
         row_ff   <= 3'd0;
         col_ff   <= 3'd0;
         bit_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         quad_ff  <= quad_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      cmd.idle        = (state_ff == ST_IDLE);
      cmd.rd_win      = (state_ff == ST_READ);
      cmd.clr_acc     = (state_ff == ST_READ) && (row_ff == 3'd0) && (col_ff == 3'd0);
      cmd.rd_border   = (state_ff == ST_BRD);
      cmd.take_border = (state_ff == ST_BRDW);
      cmd.mult        = (state_ff == ST_MUL);
      cmd.cmp         = (state_ff == ST_CMP);
      cmd.div_init    = (state_ff == ST_DINIT);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.load_out    = (state_ff == ST_DONE) && status.rsp_free;
      cmd.quad        = quad_ff;
      cmd.row         = row_ff;
      cmd.col         = col_ff;
      cmd.bitn        = bit_ff;
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status.rsp_free) |=> state_ff == ST_IDLE)
      else $error("result load did not return to idle");
   a_read_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (row_ff <= status.qm1 && col_ff <= status.qm1))
      else $error("window read outside quadrant");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DINIT) |=> (state_ff == ST_DIV && bit_ff == 3'd7))
      else $error("division did not start at the top bit");

endmodule

// ===== hw/rtl/kf_datapath.sv =====
module kf_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [kf_pkg::CSR_IW-1:0]  csr_index,
   input  logic [kf_pkg::CSR_DW-1:0]  csr_wdata,
   kf_req_if.sink                     req_chan,
   kf_rsp_if.source                   rsp_chan,
   input  kf_pkg::kf_cmd_type         cmd,
   output kf_pkg::kf_status_type      status
);
   import kf_pkg::*;

   logic [3:0]  kernel_ff;
   logic [10:0] width_ff;
   logic [10:0] height_ff;

   logic [3:0]  k_eff;
   logic [2:0]  qm1;
   logic [3:0]  q;
   logic [6:0]  n;
   logic [10:0] w_eff;
   logic [10:0] h_eff;
   logic [MEM_AW-1:0] qw;
   logic [20:0] lat;

   logic [10:0] in_row_ff, in_col_ff;
   logic [20:0] in_lin_ff;
   logic [10:0] out_h_ff, out_w_ff;
   logic [MEM_AW-1:0] out_p_ff;

   logic        full;
   logic        accept;
   logic        store;
   logic        last;

   logic [7:0]  mem [0:MEM_DEPTH-1];
   logic [7:0]  mem_q_ff;
   logic [MEM_AW-1:0] rd_addr;
   logic        pend_ff;

   logic [13:0] sum_ff;
   logic [21:0] sq_ff;
   logic [28:0] pa_ff;
   logic [27:0] pb_ff;
   logic [28:0] cost;
   logic [28:0] best_cost_ff;
   logic [13:0] best_sum_ff;
   logic [13:0] rem_ff;
   logic [7:0]  quo_ff;
   logic [14:0] dvs;

   logic        rsp_valid_ff;
   logic [7:0]  pixel_out_ff;
   logic        frame_last_ff;

   always_comb begin
      k_eff = (kernel_ff < 4'd3) ? 4'd3 : kernel_ff;
      qm1   = k_eff[3:1];
      q     = {1'b0, qm1} + 4'd1;
      n     = 7'(q * q);
      if (width_ff == 11'd0) begin
         w_eff = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         w_eff = 11'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == 11'd0) begin
         h_eff = 11'd1;
      end else if (height_ff > 11'(MAX_HEIGHT)) begin
         h_eff = 11'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      qw  = MEM_AW'(qm1 * w_eff);
      lat = 21'(qw) + 21'(qm1);
   end

   assign full   = in_row_ff >= h_eff;
   assign accept = req_chan.valid && req_chan.ready;
   assign store  = accept && !full && (req_chan.operation == OP_PIXEL);
   assign last   = (out_h_ff == h_eff - 11'd1) && (out_w_ff == w_eff - 11'd1);

   assign req_chan.ready = cmd.idle;

   always_comb begin
      status.accept   = accept;
      status.emit     = full || ((req_chan.operation == OP_PIXEL) && (in_lin_ff >= lat));
      status.interior = (out_h_ff >= 11'(q)) && ((12'(out_h_ff) + 12'(q)) < 12'(h_eff))
                        && (out_w_ff >= 11'(q)) && ((12'(out_w_ff) + 12'(q)) < 12'(w_eff));
      status.rsp_free = !rsp_valid_ff || rsp_chan.ready;
      status.qm1      = qm1;
   end

   // configuration and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= 4'd7;
         width_ff  <= 11'(MAX_WIDTH);
         height_ff <= 11'(MAX_HEIGHT);
         in_row_ff <= '0;
         in_col_ff <= '0;
         in_lin_ff <= '0;
         out_h_ff  <= '0;
         out_w_ff  <= '0;
         out_p_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KERNEL_SIZE:  kernel_ff <= csr_wdata[3:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
         if (csr_index == CSR_KERNEL_SIZE || csr_index == CSR_IMAGE_WIDTH
             || csr_index == CSR_IMAGE_HEIGHT) begin
            in_row_ff <= '0;
            in_col_ff <= '0;
            in_lin_ff <= '0;
            out_h_ff  <= '0;
            out_w_ff  <= '0;
            out_p_ff  <= '0;
         end
      end else if (cmd.load_out && last) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
         in_lin_ff <= '0;
         out_h_ff  <= '0;
         out_w_ff  <= '0;
         out_p_ff  <= '0;
      end else begin
         if (store) begin
            in_lin_ff <= in_lin_ff + 21'd1;
            if (in_col_ff + 11'd1 >= w_eff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 11'd1;
            end else begin
               in_col_ff <= in_col_ff + 11'd1;
            end
         end
         if (cmd.load_out) begin
            out_p_ff <= out_p_ff + MEM_AW'(1);
            if (out_w_ff == w_eff - 11'd1) begin
               out_w_ff <= '0;
               out_h_ff <= out_h_ff + 11'd1;
            end else begin
               out_w_ff <= out_w_ff + 11'd1;
            end
         end
      end
   end

   // line memory
   always_comb begin
      if (cmd.rd_win) begin
         rd_addr = out_p_ff - lat[MEM_AW-1:0] + (cmd.quad[1] ? qw : {MEM_AW{1'b0}})
                   + MEM_AW'(cmd.row * w_eff)
                   + (cmd.quad[0] ? MEM_AW'(qm1) : {MEM_AW{1'b0}})
                   + MEM_AW'(cmd.col);
      end else begin
         rd_addr = out_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem[in_lin_ff[MEM_AW-1:0]] <= req_chan.pixel_in;
      end
      if (cmd.rd_win || cmd.rd_border) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   assign cost = pa_ff - 29'(pb_ff);
   assign dvs  = 15'(n) << cmd.bitn;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_win;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_acc) begin
         sum_ff <= '0;
         sq_ff  <= '0;
      end else if (pend_ff) begin
         sum_ff <= sum_ff + 14'(mem_q_ff);
         sq_ff  <= sq_ff + 22'(mem_q_ff * mem_q_ff);
      end
      if (cmd.mult) begin
         pa_ff <= 29'(n * sq_ff);
         pb_ff <= 28'(sum_ff * sum_ff);
      end
      if (cmd.cmp && (cmd.quad == 2'd0 || cost < best_cost_ff)) begin
         best_cost_ff <= cost;
         best_sum_ff  <= sum_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= best_sum_ff;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if ({1'b0, rem_ff} >= dvs) begin
            rem_ff <= rem_ff - dvs[13:0];
            quo_ff[cmd.bitn] <= 1'b1;
         end
      end else if (cmd.take_border) begin
         quo_ff <= mem_q_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         pixel_out_ff  <= quo_ff;
         frame_last_ff <= last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_out  = pixel_out_ff;
   assign rsp_chan.frame_last = frame_last_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded beat not presented");
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && last && !csr_we) |=> (in_row_ff == 11'd0 && out_h_ff == 11'd0))
      else $error("frame counters not cleared after last beat");
   a_no_store_busy: assert property (@(posedge clock) disable iff (reset)
      !cmd.idle |-> !store)
      else $error("pixel stored while busy");

endmodule

// ===== hw/rtl/kuwahara_filter.sv =====
// Four-quadrant Kuwahara filter for 8-bit grayscale raster frames. Pixels enter
// on req_chan (operation 0) and results leave in raster order on rsp_chan, about
// (q-1)*width+(q-1) pixels behind, with q = kernel_size/2+1; send flush beats
// (operation 1) after the frame to drain the tail. A border result is copied
// from the line memory. For a filtered result, the single-port line memory
// delivers one window pixel per cycle of each quadrant to the sum and square
// accumulators, followed by an 8-step division.
// Configuration writes restart the frame and belong between frames.
module kuwahara_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [kf_pkg::CSR_IW-1:0]  csr_index,
   input  logic [kf_pkg::CSR_DW-1:0]  csr_wdata,
   kf_req_if.sink                     req_chan,
   kf_rsp_if.source                   rsp_chan
);
   import kf_pkg::*;

   kf_cmd_type    cmd;
   kf_status_type status;

   kf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   kf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
